// ----- sv/spfr_pkg.sv -----
// Package for the serial player frame receiver: frame constants, position codes and payload type.
package spfr_pkg;

   localparam logic [7:0] START_BYTE   = 8'h7e;
   localparam logic [7:0] VERSION_BYTE = 8'hff;
   localparam logic [7:0] LENGTH_BYTE  = 8'h06;
   localparam logic [7:0] END_BYTE     = 8'hef;

   typedef enum logic [3:0] {
      POS_HUNT      = 4'd0,
      POS_VERSION   = 4'd1,
      POS_LENGTH    = 4'd2,
      POS_COMMAND   = 4'd3,
      POS_FLAG      = 4'd4,
      POS_PARAM_HI  = 4'd5,
      POS_PARAM_LO  = 4'd6,
      POS_CHECK_HI  = 4'd7,
      POS_CHECK_LO  = 4'd8,
      POS_END       = 4'd9
   } pos_type;

   typedef struct packed {
      logic [7:0]  command;
      logic [7:0]  feedback_flag;
      logic [15:0] parameter_res;
   } rsp_payload_type;

endpackage

// ----- sv/spfr_req_if.sv -----
// Handshake interface that carries received bytes into the frame receiver.
interface spfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/spfr_rsp_if.sv -----
// Handshake interface that carries decoded frames out of the frame receiver.
interface spfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [7:0]  feedback_flag;
   logic [15:0] parameter_res;

   modport source (output valid, output command, output feedback_flag,
                   output parameter_res, input ready);
   modport sink (input valid, input command, input feedback_flag,
                 input parameter_res, output ready);
endinterface

// ----- sv/serial_player_frame_receiver.sv -----
// Top level of the serial player frame receiver: input register, parser and result register.
// Path: an accepted byte is held in the input register until the parser steps on it; the
// step on a frame's end byte loads the result register, which then offers the result.
// Throughput: one byte per cycle, one parser step per byte, while the output is free; a held
// result that is not taken stalls the input register only while it waits.
// Reset is synchronous and active high; it empties both registers and returns to hunting.
module serial_player_frame_receiver (
   input  logic clock,
   input  logic reset,
   spfr_req_if.sink   req_chan,
   spfr_rsp_if.source rsp_chan
);
   import spfr_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            advance;
   logic            emit;
   rsp_payload_type payload;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   spfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .payload (payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_data_ff <= payload;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.command       = out_data_ff.command;
   assign rsp_chan.feedback_flag = out_data_ff.feedback_flag;
   assign rsp_chan.parameter_res = out_data_ff.parameter_res;

endmodule

// ----- sv/spfr_parser.sv -----
// Frame position state machine with running checksum and held payload bytes.
module spfr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   output logic                      emit,
   output spfr_pkg::rsp_payload_type payload
);
   import spfr_pkg::*;

   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [15:0] sum_ff;
   logic [15:0] sum_in;
   logic [7:0]  cmd_ff;
   logic [7:0]  flag_ff;
   logic [7:0]  phi_ff;
   logic [7:0]  plo_ff;
   logic [15:0] check;

   assign check = 16'd0 - sum_ff;

   always_comb begin
      pos_in = 4'(POS_HUNT);
      sum_in = 16'd0;
      emit   = 1'b0;
      unique case (pos_ff)
         4'(POS_HUNT): begin
            if (rx_byte == START_BYTE) begin
               pos_in = 4'(POS_VERSION);
            end
         end
         4'(POS_VERSION): begin
            if (rx_byte == VERSION_BYTE) begin
               pos_in = 4'(POS_LENGTH);
               sum_in = sum_ff + {8'd0, rx_byte};
            end
         end
         4'(POS_LENGTH): begin
            if (rx_byte == LENGTH_BYTE) begin
               pos_in = 4'(POS_COMMAND);
               sum_in = sum_ff + {8'd0, rx_byte};
            end
         end
         4'(POS_COMMAND), 4'(POS_FLAG), 4'(POS_PARAM_HI), 4'(POS_PARAM_LO): begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_ff + {8'd0, rx_byte};
         end
         4'(POS_CHECK_HI): begin
            if (rx_byte == check[15:8]) begin
               pos_in = 4'(POS_CHECK_LO);
               sum_in = sum_ff;
            end
         end
         4'(POS_CHECK_LO): begin
            if (rx_byte == check[7:0]) begin
               pos_in = 4'(POS_END);
               sum_in = sum_ff;
            end
         end
         4'(POS_END): begin
            emit = step && (rx_byte == END_BYTE);
         end
         default: begin
            pos_in = 4'(POS_HUNT);
         end
      endcase
   end

   assign payload.command       = cmd_ff;
   assign payload.feedback_flag = flag_ff;
   assign payload.parameter_res = {phi_ff, plo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'(POS_HUNT);
         sum_ff <= 16'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (pos_ff == 4'(POS_COMMAND)) cmd_ff <= rx_byte;
         if (pos_ff == 4'(POS_FLAG)) flag_ff <= rx_byte;
         if (pos_ff == 4'(POS_PARAM_HI)) phi_ff <= rx_byte;
         if (pos_ff == 4'(POS_PARAM_LO)) plo_ff <= rx_byte;
      end
   end

endmodule
